FILE: rtl/svmk_pkg.sv
package svmk_pkg;

    // element and term widths
    localparam int VALUE_WIDTH = 16;
    localparam int FRAC_BITS   = VALUE_WIDTH - 4;
    localparam int SUM_SHIFT   = 2 * FRAC_BITS;
    localparam int OPND_W      = VALUE_WIDTH + 1;
    localparam int TERM_W      = 2 * OPND_W;
    localparam int IN_DATA_W   = ((2 * VALUE_WIDTH + 7) / 8) * 8;

    // accumulator and result
    localparam int ACC_W      = 48;
    localparam int SUM_W      = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
    localparam int RES_W      = 48;
    localparam int OUT_DATA_W = ((RES_W + 1 + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] ACC_MAX_S = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_MIN_S = -ACC_MAX_S - SUM_W'(1);

    // exponential datapath
    localparam int GAMMA_W   = 24;
    localparam int US_W      = ACC_W - 1;
    localparam int UHI_W     = US_W - GAMMA_W;
    localparam int FULL_W    = GAMMA_W + US_W;
    localparam int T_W       = 25;
    localparam int LOG2E_W   = 31;
    localparam int ZPROD_W   = T_W + LOG2E_W;
    localparam int Z_W       = 25;
    localparam int ZF_W      = 16;
    localparam int ZI_W      = Z_W - ZF_W;
    localparam int Q_W       = 30;
    localparam int M_W       = 31;
    localparam int MPROD_W   = M_W + Q_W;
    localparam int RND_W     = 56;
    localparam int EXP_STEPS = 16;
    localparam int STEP_W    = 4;
    localparam int ZI_MAX    = 40;

    localparam logic [FULL_W-1:0]  T_CAP      = FULL_W'(1) << 24;
    localparam logic [LOG2E_W-1:0] LOG2E_Q30  = 31'h5C551D95;
    localparam logic [ZPROD_W-1:0] Z_ROUND    = ZPROD_W'(1) << 29;
    localparam logic [MPROD_W-1:0] M_ROUND    = MPROD_W'(1) << 29;
    localparam logic [M_W-1:0]     M_ONE      = M_W'(1) << 30;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_KERNEL_MODE = 1'b0;
    localparam logic REG_GAMMA       = 1'b1;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_RBF    = 1'b1
    } kernel_mode_t;

    typedef struct packed {
        kernel_mode_t             kernel_mode;
        logic [GAMMA_W-1:0]       gamma;
    } cfg_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        kernel_mode_t             mode;
        logic                     last;
    } term_item_t;

    typedef logic [EXP_STEPS-1:0][Q_W-1:0] q_table_t;

    // floor square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // factors 2^(-2^-(i+1)) in q0.30
    function automatic q_table_t build_q_table();
        q_table_t    q;
        logic [63:0] prev;
        prev = isqrt64(64'd1 << 59);
        q[0] = prev[Q_W-1:0];
        for (int i = 1; i < EXP_STEPS; i++) begin
            prev = isqrt64(prev << 30);
            q[i] = prev[Q_W-1:0];
        end
        return q;
    endfunction

    localparam q_table_t Q_TABLE = build_q_table();

endpackage

FILE: rtl/svmk_front.sv
module svmk_front
    import svmk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  cfg_t                 cfg,
    input  logic                 queue_full,
    output logic                 push,
    output term_item_t           push_item
);

    logic                     opnd_valid_reg;
    logic signed [OPND_W-1:0] opnd_a_reg;
    logic signed [OPND_W-1:0] opnd_b_reg;
    kernel_mode_t             mode_reg;
    logic                     last_reg;

    logic signed [VALUE_WIDTH-1:0] x_val;
    logic signed [VALUE_WIDTH-1:0] y_val;
    logic signed [OPND_W-1:0]      x_ext;
    logic signed [OPND_W-1:0]      y_ext;
    logic signed [OPND_W-1:0]      diff;
    logic signed [OPND_W-1:0]      opnd_a_next;
    logic signed [OPND_W-1:0]      opnd_b_next;
    logic                          accept;

    // operand selection: x*y or (x-y)^2
    always_comb begin
        x_val = s_axis_tdata[VALUE_WIDTH-1:0];
        y_val = s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
        x_ext = OPND_W'(x_val);
        y_ext = OPND_W'(y_val);
        diff  = x_ext - y_ext;
        if (cfg.kernel_mode == MODE_RBF) begin
            opnd_a_next = diff;
            opnd_b_next = diff;
        end else begin
            opnd_a_next = x_ext;
            opnd_b_next = y_ext;
        end
    end

    assign s_axis_tready = !opnd_valid_reg || !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = opnd_valid_reg && !queue_full;

    // multiply stage feeds the queue write port
    always_comb begin
        push_item.term = opnd_a_reg * opnd_b_reg;
        push_item.mode = mode_reg;
        push_item.last = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opnd_valid_reg <= 1'b0;
        end else if (accept) begin
            opnd_valid_reg <= 1'b1;
        end else if (push) begin
            opnd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            opnd_a_reg <= opnd_a_next;
            opnd_b_reg <= opnd_b_next;
            mode_reg   <= cfg.kernel_mode;
            last_reg   <= s_axis_tlast;
        end
    end

endmodule

FILE: rtl/svmk_queue.sv
module svmk_queue
    import svmk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  term_item_t push_item,
    output logic       full,
    input  logic       pop,
    output term_item_t pop_item,
    output logic       empty
);

    term_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/svmk_back.sv
module svmk_back
    import svmk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  empty,
    input  term_item_t            pop_item,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [8:0] {
        ST_ACC    = 9'b000000001,
        ST_MUL_LO = 9'b000000010,
        ST_MUL_HI = 9'b000000100,
        ST_T      = 9'b000001000,
        ST_Z      = 9'b000010000,
        ST_ZR     = 9'b000100000,
        ST_POW    = 9'b001000000,
        ST_ROUND  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     clip_reg;
    logic signed [RES_W-1:0]  res_value_reg;
    logic                     res_clip_reg;
    logic [US_W-1:0]          us_reg;
    logic [2*GAMMA_W-1:0]     lo_prod_reg;
    logic [GAMMA_W+UHI_W-1:0] hi_prod_reg;
    logic [T_W-1:0]           t_reg;
    logic [ZPROD_W-1:0]       zprod_reg;
    logic [Z_W-1:0]           z_reg;
    logic [M_W-1:0]           m_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     m_valid_reg;
    logic signed [RES_W-1:0]  m_value_reg;
    logic                     m_sat_reg;

    logic signed [SUM_W-1:0]  sum;
    logic signed [ACC_W-1:0]  acc_new;
    logic                     clip_new;
    logic [FULL_W-1:0]        full_prod;
    logic [FULL_W-1:0]        t_shift;
    logic [T_W-1:0]           t_next;
    logic [ZPROD_W-1:0]       zrnd;
    logic [MPROD_W-1:0]       mprod;
    logic [ZF_W-1:0]          zf;
    logic [ZI_W-1:0]          zi;
    logic [5:0]               rnd_sh;
    logic [RND_W-1:0]         rnd;
    logic [RES_W-1:0]         exp_res;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign pop      = (state_reg == ST_ACC) && !empty;

    // saturating accumulate
    always_comb begin
        sum      = SUM_W'(acc_reg) + SUM_W'(pop_item.term);
        clip_new = clip_reg;
        if (sum > ACC_MAX_S) begin
            acc_new  = ACC_MAX_S[ACC_W-1:0];
            clip_new = 1'b1;
        end else if (sum < ACC_MIN_S) begin
            acc_new  = ACC_MIN_S[ACC_W-1:0];
            clip_new = 1'b1;
        end else begin
            acc_new = sum[ACC_W-1:0];
        end
    end

    // scaled exponent argument, capped
    always_comb begin
        full_prod = (FULL_W'(hi_prod_reg) << GAMMA_W) + FULL_W'(lo_prod_reg);
        t_shift   = full_prod >> SUM_SHIFT;
        if (t_shift > T_CAP) begin
            t_next = T_CAP[T_W-1:0];
        end else begin
            t_next = t_shift[T_W-1:0];
        end
    end

    // exponent split, power step and final rounding
    always_comb begin
        zrnd   = zprod_reg + Z_ROUND;
        zf     = z_reg[ZF_W-1:0];
        zi     = z_reg[Z_W-1:ZF_W];
        mprod  = MPROD_W'(m_reg) * MPROD_W'(Q_TABLE[step_reg]) + M_ROUND;
        rnd_sh = 6'd14 + zi[5:0];
        rnd    = RND_W'(m_reg) + (RND_W'(1) << (rnd_sh - 6'd1));
        if (zi > ZI_W'(ZI_MAX)) begin
            exp_res = '0;
        end else begin
            exp_res = RES_W'(rnd >> rnd_sh);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (pop && pop_item.last) begin
                    state_next = (pop_item.mode == MODE_RBF) ? ST_MUL_LO : ST_OUT;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_T;
            ST_T:      state_next = ST_Z;
            ST_Z:      state_next = ST_ZR;
            ST_ZR:     state_next = ST_POW;
            ST_POW: begin
                if (step_reg == STEP_W'(EXP_STEPS - 1)) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_ACC;
                end
            end
            default:   state_next = ST_ACC;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                if (pop_item.last) begin
                    acc_reg  <= '0;
                    clip_reg <= 1'b0;
                end else begin
                    acc_reg  <= acc_new;
                    clip_reg <= clip_new;
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_ACC: begin
                if (pop && pop_item.last) begin
                    res_clip_reg  <= clip_new;
                    res_value_reg <= RES_W'(acc_new);
                    us_reg        <= acc_new[ACC_W-1] ? '0 : acc_new[US_W-1:0];
                end
            end
            ST_MUL_LO: lo_prod_reg <= cfg.gamma * us_reg[GAMMA_W-1:0];
            ST_MUL_HI: hi_prod_reg <= cfg.gamma * us_reg[US_W-1:GAMMA_W];
            ST_T:      t_reg <= t_next;
            ST_Z:      zprod_reg <= ZPROD_W'(t_reg) * ZPROD_W'(LOG2E_Q30);
            ST_ZR: begin
                z_reg    <= zrnd[30 +: Z_W];
                m_reg    <= M_ONE;
                step_reg <= '0;
            end
            ST_POW: begin
                if (zf[STEP_W'(EXP_STEPS - 1) - step_reg]) begin
                    m_reg <= mprod[30 +: M_W];
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_ROUND:  res_value_reg <= exp_res;
            ST_OUT: begin
                if (out_free) begin
                    m_value_reg <= res_value_reg;
                    m_sat_reg   <= res_clip_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({m_sat_reg, m_value_reg});

endmodule

FILE: rtl/svm_kernel_linear_rbf_core.sv
// channel   dir  ports                      payload
// s_axis    in   tvalid tready tdata tlast  tdata: x_value[15:0] y_value[31:16]; tlast: last
// m_axis    out  tvalid tready tdata        tdata: kernel_value[47:0] saturated[48], zero fill
// apb       in   psel penable pwrite paddr  0x0 kernel_mode, 0x4 gamma (q8.16)
//
// one element pair per cycle is taken while the four-entry term queue has room.
// a linear result raises m_axis_tvalid once its last pair is taken and the sum registered; an rbf
// result first passes through the scaling, the exponent split and the sixteen serial multiply
// steps of the power unit, and the queue then fills and holds off the input.
// aresetn is synchronous, active low; it clears the accumulator, queue and handshakes.
// either side may stall at any time; the output register frees the back end.
module svm_kernel_linear_rbf_core
    import svmk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // x_value, y_value
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // kernel_value, saturated
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    kernel_mode_t       kernel_mode_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    cfg_t               cfg;
    logic               cfg_write;
    logic               reg_sel;

    logic       queue_full;
    logic       queue_empty;
    logic       push;
    logic       pop;
    term_item_t push_item;
    term_item_t pop_item;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_mode_reg <= MODE_RBF;
            gamma_reg       <= GAMMA_W'(65536);
        end else if (cfg_write) begin
            case (reg_sel)
                REG_KERNEL_MODE: kernel_mode_reg <= kernel_mode_t'(pwdata[0]);
                REG_GAMMA:       gamma_reg <= pwdata[GAMMA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_KERNEL_MODE: prdata = CFG_DATA_W'(kernel_mode_reg);
            REG_GAMMA:       prdata = CFG_DATA_W'(gamma_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.kernel_mode = kernel_mode_reg;
    assign cfg.gamma       = gamma_reg;

    svmk_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg           (cfg),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    svmk_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    svmk_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .empty         (queue_empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
